/* rtl/bfms_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bfms_pkg: shared types and constants for the bf16 multi-operand sum
// Holds the stage payload struct and constants.
// ----------------------------------------------------------------------------
package bfms_pkg;

  localparam int unsigned NumOperands = 8;
  localparam logic [15:0] NanOut     = 16'hffff;
  localparam logic [31:0] RoundBias  = 32'h0000_7fff;

  // Item moving down the adder chain
  typedef struct packed {
    logic [31:0] acc;       // running binary32 sum
    logic        bypass;    // single operand: pass operand 0 as is
    logic [15:0] raw0;      // operand 0 bits for the bypass case
    logic [3:0]  count;     // saturated operand count, 0..8
    logic        last;
  } stage_t;

endpackage : bfms_pkg
`default_nettype wire

/* rtl/bf16_multi_operand_sum_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bf16_multi_operand_sum_top: sum of up to eight bf16 operands
// Takes one transfer per cycle unless stalled; nine register levels (input
// register, seven binary32 adder stages, output rounding register). A stall
// freezes the whole pipe; each adder stage holds one binary32 add with
// rounding.
// ----------------------------------------------------------------------------
module bf16_multi_operand_sum_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] value_0,
  input  wire logic [15:0] value_1,
  input  wire logic [15:0] value_2,
  input  wire logic [15:0] value_3,
  input  wire logic [15:0] value_4,
  input  wire logic [15:0] value_5,
  input  wire logic [15:0] value_6,
  input  wire logic [15:0] value_7,
  input  wire logic        end_of_vector,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      sum_value,
  output logic             last_out
);

  localparam int unsigned N = bfms_pkg::NumOperands;

  logic [3:0]              operand_count;
  logic                    en;
  logic                    entry_valid;
  bfms_pkg::stage_t        entry_item;
  logic [N-1:0]            v;
  bfms_pkg::stage_t        item [N];
  logic [15:0]             ops  [N][N];
  logic [31:0]             rw;
  logic [15:0]             rounded;

  always_ff @(posedge clk) begin
    if (rst) begin
      operand_count <= 4'd8;
    end else if (cfg_we) begin
      operand_count <= cfg_wdata;
    end
  end

  // whole pipe advances unless the output is held
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // entry stage
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (en) begin
      entry_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      entry_item.acc    <= {value_0, 16'd0};
      entry_item.raw0   <= value_0;
      entry_item.last   <= end_of_vector;
      entry_item.bypass <= (operand_count <= 4'd1);
      entry_item.count  <= (operand_count > 4'd8) ? 4'd8 : operand_count;
      ops[0][1] <= value_1; ops[0][2] <= value_2; ops[0][3] <= value_3;
      ops[0][4] <= value_4; ops[0][5] <= value_5; ops[0][6] <= value_6;
      ops[0][7] <= value_7;
    end
  end

  assign v[0]    = entry_valid;
  assign item[0] = entry_item;

  // operand delay lines, one row per stage
  for (genvar s = 1; s < N; s++) begin : g_ops
    for (genvar k = s + 1; k < N; k++) begin : g_k
      always_ff @(posedge clk) begin
        if (en) ops[s][k] <= ops[s-1][k];
      end
    end
  end

  for (genvar s = 1; s < N; s++) begin : g_stage
    bfms_add_stage #(.Index(s)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (v[s-1]),
      .in_item   (item[s-1]),
      .operand   (ops[s-1][s]),
      .out_valid (v[s]),
      .out_item  (item[s])
    );
  end

  // round to bf16
  always_comb begin
    rw      = item[N-1].acc + bfms_pkg::RoundBias + {31'd0, item[N-1].acc[16]};
    rounded = rw[31:16];
    if (item[N-1].bypass) rounded = item[N-1].raw0;
    else if (item[N-1].acc[30:23] == 8'hff && item[N-1].acc[22:0] != 23'd0)
      rounded = bfms_pkg::NanOut;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_value <= rounded;
      last_out  <= item[N-1].last;
    end
  end

endmodule : bf16_multi_operand_sum_top
`default_nettype wire

/* rtl/bfms_fp32_add.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bfms_fp32_add: combinational binary32 adder, round to nearest even
// Full IEEE handling of subnormals, infinities and NaN (NaN output is 7fc00000).
// ----------------------------------------------------------------------------
module bfms_fp32_add (
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [31:0] y
);

  logic        sa, sb, sl, ss;
  logic [7:0]  ea, eb, el, es;
  logic [23:0] ma, mb, ml, ms;
  logic [7:0]  d;
  logic [26:0] xl, xs, xs_sh;
  logic [27:0] sum;
  logic        sticky;
  logic [4:0]  lz;
  logic [9:0]  e_res;
  logic [27:0] norm;
  logic [23:0] mant;
  logic        g_bit, r_bit, st;
  logic [24:0] rnd;
  logic [9:0]  e_fin;
  logic        a_nan, b_nan, a_inf, b_inf;
  logic        swap;
  logic [53:0] wide;

  always_comb begin
    sa = a[31]; sb = b[31];
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {(a[30:23] != 8'd0), a[22:0]};
    mb = {(b[30:23] != 8'd0), b[22:0]};
    a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
    // order by magnitude
    swap = (b[30:0] > a[30:0]);
    sl = swap ? sb : sa;  ss = swap ? sa : sb;
    el = swap ? eb : ea;  es = swap ? ea : eb;
    ml = swap ? mb : ma;  ms = swap ? ma : mb;
    d  = el - es;
    xl = {ml, 3'b000};
    // align smaller operand, keep sticky
    wide  = {ms, 30'd0} >> ((d > 8'd30) ? 8'd30 : d);
    xs_sh = {wide[53:28], (wide[27:0] != 28'd0)};
    xs    = xs_sh;
    sticky = 1'b0;
    if (sl == ss) sum = {1'b0, xl} + {1'b0, xs};
    else          sum = {1'b0, xl} - {1'b0, xs};
    // leading zero count over the 28-bit sum
    lz = 5'd28;
    for (int i = 0; i < 28; i++) begin
      if (sum[i]) lz = 5'(27 - i);
    end
    // normalize: target leading one at bit 26 (bit 27 means carry)
    if (sum[27]) begin
      norm  = {1'b0, sum[27:2], sum[1] | sum[0]};
      e_res = {2'b00, el} + 10'd1;
    end else if ({5'd0, lz} - 10'd1 < {2'b00, el} - 10'd1 || lz == 5'd1) begin
      norm  = sum << (lz - 5'd1);
      e_res = {2'b00, el} - {5'd0, lz} + 10'd1;
    end else begin
      // result subnormal: shift only down to exponent 1
      norm  = sum << (el - 8'd1);
      e_res = 10'd0;
    end
    mant  = norm[26:3];
    g_bit = norm[2]; r_bit = norm[1]; st = norm[0] | sticky;
    rnd   = {1'b0, mant} + {24'd0, (g_bit & (r_bit | st | mant[0]))};
    e_fin = e_res;
    if (e_res == 10'd0) begin
      // subnormal may round up into normal range
      e_fin = rnd[23] ? 10'd1 : 10'd0;
    end else if (rnd[24]) begin
      e_fin = e_res + 10'd1;
      rnd   = rnd >> 1;
    end
    if (a_nan || b_nan || (a_inf && b_inf && (sa != sb)))
      y = 32'h7fc0_0000;
    else if (a_inf) y = a;
    else if (b_inf) y = b;
    else if (sum == 28'd0)
      y = {sa & sb, 31'd0};
    else if (e_fin >= 10'd255)
      y = {sl, 8'hff, 23'd0};
    else
      y = {sl, e_fin[7:0], rnd[22:0]};
  end

endmodule : bfms_fp32_add
`default_nettype wire

/* rtl/bfms_add_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bfms_add_stage: one registered step of the adder chain
// Adds operand Index into the running sum when Index is below the count.
// ----------------------------------------------------------------------------
module bfms_add_stage #(
  parameter int unsigned Index = 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire bfms_pkg::stage_t in_item,
  input  wire logic [15:0]      operand,
  output logic                  out_valid,
  output bfms_pkg::stage_t      out_item
);

  logic [31:0]      add_y;
  bfms_pkg::stage_t item_next;

  bfms_fp32_add u_add (
    .a (in_item.acc),
    .b ({operand, 16'd0}),
    .y (add_y)
  );

  // valid tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // operands at or past the count leave the sum alone
  always_comb begin
    item_next = in_item;
    if (in_item.count > 4'(Index)) item_next.acc = add_y;
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule : bfms_add_stage
`default_nettype wire

/* dv/bf16_multi_operand_sum_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bf16_multi_operand_sum_top_test: self-checking bench for the bf16 sum block
// Drives operand sets over valid/ready, predicts each rounded bf16 sum with
// bit-exact binary32 accumulation, and checks results in order.
// ----------------------------------------------------------------------------
module bf16_multi_operand_sum_top_test;

  typedef struct {
    logic [15:0] sum;
    logic        last;
  } sum_item_t;

  // Scoreboard: predicts sums for accepted sets and checks results in order
  class sum_scoreboard;
    sum_item_t   pending_sums[$];
    int          errors;
    int          checked;
    logic [3:0]  count_reg;

    function new();
      errors    = 0;
      checked   = 0;
      count_reg = 4'd8;
    endfunction

    // binary32 value as an integer count of 2^-149 units
    function logic [287:0] to_fixed(logic [31:0] x);
      if (x[30:23] == 8'd0) return {265'd0, x[22:0]};
      return {264'd0, 1'b1, x[22:0]} << (x[30:23] - 8'd1);
    endfunction

    // exact sum, then one round to nearest even; NaN comes out quiet
    function logic [31:0] fp32_add(logic [31:0] a, logic [31:0] b);
      logic [287:0] ma, mb, m, rem, half;
      logic [23:0]  q;
      logic         s, up;
      logic         a_nan, b_nan, a_inf, b_inf;
      int           p, sh, ex;
      a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
      b_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
      a_inf = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
      b_inf = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
      if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) return 32'h7fc0_0000;
      if (a_inf) return a;
      if (b_inf) return b;
      ma = to_fixed(a);
      mb = to_fixed(b);
      if (a[31] == b[31]) begin
        m = ma + mb; s = a[31];
      end else if (ma >= mb) begin
        m = ma - mb; s = a[31];
      end else begin
        m = mb - ma; s = b[31];
      end
      if (m == '0) return {a[31] & b[31], 31'd0};
      p = 0;
      for (int i = 0; i < 288; i++) if (m[i]) p = i;
      // below 2^24 units the pattern is the magnitude itself
      if (p < 24) return {s, m[30:0]};
      sh   = p - 23;
      q    = 24'(m >> sh);
      rem  = m & ((288'd1 << sh) - 288'd1);
      half = 288'd1 << (sh - 1);
      up   = (rem > half) || ((rem == half) && q[0]);
      ex   = sh + 1;
      if (up) begin
        if (q == 24'hff_ffff) begin
          q  = 24'h80_0000;
          ex = ex + 1;
        end else begin
          q = q + 24'd1;
        end
      end
      if (ex >= 255) return {s, 8'hff, 23'd0};
      return {s, 8'(ex), q[22:0]};
    endfunction

    function logic [15:0] narrow_bf16(logic [31:0] w);
      logic [31:0] r;
      if (w[30:23] == 8'hff && w[22:0] != 23'd0) return bfms_pkg::NanOut;
      r = w + bfms_pkg::RoundBias + {31'd0, w[16]};
      return r[31:16];
    endfunction

    function void note_set(logic [15:0] ops[8], logic eov);
      sum_item_t    e;
      int           n;
      logic [31:0]  acc;
      n = count_reg;
      if (n == 0) n = 1;
      if (n > bfms_pkg::NumOperands) n = bfms_pkg::NumOperands;
      if (n == 1) begin
        e.sum = ops[0];
      end else begin
        acc = {ops[0], 16'h0};
        for (int i = 1; i < n; i++) acc = fp32_add(acc, {ops[i], 16'h0});
        e.sum = narrow_bf16(acc);
      end
      e.last = eov;
      pending_sums.push_back(e);
    endfunction

    function void check_sum(logic [15:0] sum, logic last);
      sum_item_t e;
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected result sum=%h last=%b", $time, sum, last);
        errors++;
        return;
      end
      e = pending_sums.pop_front();
      checked++;
      if (sum !== e.sum) begin
        $display("%0t: sum_value expected %h actual %h", $time, e.sum, sum);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last_out expected %b actual %b", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] value_0, value_1, value_2, value_3;
  logic [15:0] value_4, value_5, value_6, value_7;
  logic        end_of_vector;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] sum_value;
  logic        last_out;

  sum_scoreboard sb;
  int  cycle_count;
  bit  hold_off;
  bit  stim_done;

  bf16_multi_operand_sum_top u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .value_0(value_0), .value_1(value_1), .value_2(value_2), .value_3(value_3),
    .value_4(value_4), .value_5(value_5), .value_6(value_6), .value_7(value_7),
    .end_of_vector(end_of_vector), .out_valid(out_valid), .out_ready(out_ready),
    .sum_value(sum_value), .last_out(last_out)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // Timeout watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: sample at rising edge, random stalls, one long hold-off
  initial begin
    int gap;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        out_ready = 1'b0;
        repeat (60) @(negedge clk);
        hold_off = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      out_ready = 1'b0;
      repeat (gap) @(negedge clk);
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_sum(sum_value, last_out);
      @(negedge clk);
    end
  end

  // Offer one operand set and wait for its transfer
  task automatic send_set(logic [15:0] ops[8], logic eov, int gap);
    in_valid = 1'b0;
    repeat (gap) @(negedge clk);
    {value_0, value_1, value_2, value_3} = {ops[0], ops[1], ops[2], ops[3]};
    {value_4, value_5, value_6, value_7} = {ops[4], ops[5], ops[6], ops[7]};
    end_of_vector = eov;
    in_valid      = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_set(ops, eov);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Wait for the pipe to drain, then write the operand count
  task automatic set_count(logic [3:0] cnt);
    while (sb.pending_sums.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = cnt;
    @(negedge clk);
    cfg_we    = 1'b0;
    sb.count_reg = cnt;
  endtask

  // Random bf16 pattern, biased toward similar exponents and special values
  function automatic logic [15:0] pick_bf16();
    case ($urandom_range(0, 9))
      0:       return 16'(($urandom_range(0, 1) << 15) | 16'h7f80);
      1:       return 16'(($urandom_range(0, 1) << 15) | $urandom_range(0, 127));
      2:       return 16'(($urandom_range(0, 1) << 15) | 16'h7f7f);
      3:       return 16'($urandom);
      default: return 16'(($urandom_range(0, 1) << 15) | ($urandom_range(120, 134) << 7)
                          | $urandom_range(0, 127));
    endcase
  endfunction

  initial begin
    logic [15:0] ops[8];
    logic [3:0]  counts[6];
    counts = '{4'd1, 4'd2, 4'd5, 4'd15, 4'd0, 4'd7};
    sb = new();
    rst = 1'b1; cfg_we = 1'b0; cfg_wdata = '0; in_valid = 1'b0; end_of_vector = 1'b0;
    {value_0, value_1, value_2, value_3} = '0;
    {value_4, value_5, value_6, value_7} = '0;
    cycle_count = 0; hold_off = 1'b0; stim_done = 1'b0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Directed: field extremes, infinities, NaN, rounding overflow, cancellation
    begin
      logic [15:0] dir[12];
      dir = '{16'h0000, 16'hffff, 16'h7f80, 16'hff80, 16'h7fc0,
              16'h7f7f, 16'hff7f, 16'h0001, 16'h8001, 16'h3f80,
              16'hbf80, 16'h8000};
      foreach (dir[k]) begin
        foreach (ops[i]) ops[i] = dir[(k + i) % 12];
        send_set(ops, k[0], 0);
      end
      foreach (ops[i]) ops[i] = 16'h7f7f;
      send_set(ops, 1'b1, 0);
      foreach (ops[i]) ops[i] = (i == 0) ? 16'h7f7f : 16'h7400;
      send_set(ops, 1'b0, 1);
      foreach (ops[i]) ops[i] = i[0] ? 16'h3f81 : 16'hbf80;
      send_set(ops, 1'b1, 2);
    end
    set_count(4'd1);
    foreach (ops[i]) ops[i] = 16'h7fc1 ^ 16'(i);
    send_set(ops, 1'b1, 0);

    // Random phases through several counts; one long receiver hold-off
    foreach (counts[c]) begin
      set_count(counts[c]);
      if (c == 2) hold_off = 1'b1;
      repeat (65) begin
        foreach (ops[i]) ops[i] = pick_bf16();
        send_set(ops, $urandom_range(0, 1),
                 ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6));
      end
    end
    set_count(4'd8);
    repeat (10) begin
      foreach (ops[i]) ops[i] = pick_bf16();
      send_set(ops, $urandom_range(0, 1), 0);
    end

    while (sb.pending_sums.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Covered %0d checked sums over operand counts 0,1,2,5,7,8,15,", sb.checked);
    $display("with specials, rounding overflow and a long output stall.");
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/bfms_pkg.sv
rtl/bfms_fp32_add.sv
rtl/bfms_add_stage.sv
rtl/bf16_multi_operand_sum_top.sv
dv/bf16_multi_operand_sum_top_test.sv
